// ===== src/dllp_pkg.sv =====
// ============================================================================
// dllp_pkg
// Shared constants, codes and helpers of the linked list pool unit.
// ============================================================================
package dllp_pkg;

    // Node pool size; handle 0 is the head sentinel, handles 1..POOL_NODES are nodes
    localparam int POOL_NODES = 1024;
    localparam int HANDLE_W   = $clog2(POOL_NODES + 1);
    localparam int ADDR_W     = $clog2(POOL_NODES);
    localparam int VALUE_W    = 64;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    // Stream data width: handle and value packed, rounded up to whole bytes
    localparam int TDATA_W = 8 * ((HANDLE_W + VALUE_W + 7) / 8);

    localparam logic [HANDLE_W-1:0] POOL_LAST = HANDLE_W'(POOL_NODES);

    typedef enum logic [OP_W-1:0] {
        OP_INS_AFTER  = 3'd0,
        OP_INS_BEFORE = 3'd1,
        OP_ERASE      = 3'd2,
        OP_NEXT       = 3'd3,
        OP_PREV       = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NOT_LIVE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_LINK,
        ST_FETCH
    } state_t;

    // Map a node handle to its memory slot (handle 1 sits at slot 0)
    function automatic logic [ADDR_W-1:0] slot_of(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_W-1:0] d;
        d = h - HANDLE_W'(1);
        return d[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/dllp_ram.sv =====
// ============================================================================
// dllp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module dllp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/doubly_linked_list_pool_unit.sv =====
// ============================================================================
// doubly_linked_list_pool_unit
// Circular doubly linked list in a fixed node pool with a head sentinel.
// ============================================================================
// Sequence: a result beat is loaded in ST_LOOK, or in ST_FETCH for next and prev, and
//   waits there while the output register holds an untaken beat. Erase, clear and
//   rejected operations pass ST_IDLE and ST_LOOK; insert adds ST_LINK, set by the one
//   write port of each link memory, and next and prev add ST_FETCH for the second value memory read.
// Reset: rst_n clears the fill count and the sentinel links; the list is empty
//   at once, with no clearing pass. Node memories are never reset.
module doubly_linked_list_pool_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [10:0] where_handle, [74:11] new_value, rest zero
    input  logic [dllp_pkg::TDATA_W-1:0]  s_axis_tdata,
    // [2:0] op
    input  logic [dllp_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [10:0] result_handle, [74:11] result_value, rest zero
    output logic [dllp_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [dllp_pkg::STATUS_W-1:0] m_axis_tuser
);

    localparam int HW = dllp_pkg::HANDLE_W;
    localparam int AW = dllp_pkg::ADDR_W;
    localparam int VW = dllp_pkg::VALUE_W;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    dllp_pkg::state_t state_reg, state_next;

    logic [HW-1:0] alloc_count_reg, alloc_count_next;
    logic [HW-1:0] head_nxt_reg, head_nxt_next;   // sentinel next link (first node)
    logic [HW-1:0] head_prv_reg, head_prv_next;   // sentinel prev link (last node)

    // Held input beat
    dllp_pkg::op_t op_reg;
    logic [HW-1:0] hnd_reg;
    logic [VW-1:0] val_reg;

    // Neighbors kept between the steps of one operation
    logic [HW-1:0] left_reg, left_next;
    logic [HW-1:0] right_reg, right_next;
    logic [HW-1:0] nbr_reg, nbr_next;

    // Output register
    logic                    out_valid_reg;
    logic [HW-1:0]           out_handle_reg;
    logic [VW-1:0]           out_value_reg;
    dllp_pkg::status_t       out_status_reg;

    // ------------------------------------------------------------------
    // Node memories: links, values and live marks of handles 1..POOL_NODES
    // ------------------------------------------------------------------
    logic          nxt_we, prv_we, val_we, live_we;
    logic [AW-1:0] nxt_waddr, prv_waddr, val_waddr, live_waddr;
    logic [HW-1:0] nxt_wdata, prv_wdata;
    logic [VW-1:0] val_wdata;
    logic          live_wdata;
    logic [AW-1:0] link_raddr, val_raddr;
    logic [HW-1:0] nxt_rd, prv_rd;
    logic [VW-1:0] val_rd;
    logic          live_rd;

    dllp_ram #(.WIDTH(HW), .DEPTH(dllp_pkg::POOL_NODES)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (link_raddr),
        .rdata (nxt_rd)
    );

    dllp_ram #(.WIDTH(HW), .DEPTH(dllp_pkg::POOL_NODES)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (link_raddr),
        .rdata (prv_rd)
    );

    dllp_ram #(.WIDTH(VW), .DEPTH(dllp_pkg::POOL_NODES)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rd)
    );

    dllp_ram #(.WIDTH(1), .DEPTH(dllp_pkg::POOL_NODES)) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (link_raddr),
        .rdata (live_rd)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic          in_beat;
    logic          out_free;
    logic [HW-1:0] in_handle;

    // One operation at a time: take a beat only between operations
    assign s_axis_tready = (state_reg == dllp_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign in_handle     = s_axis_tdata[HW-1:0];
    // The output register can take a new result this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Decode of the looked-up node (valid in ST_LOOK)
    // ------------------------------------------------------------------
    logic          hnd_live;
    logic          hnd_ok;
    logic          pool_full;
    logic [HW-1:0] new_handle;
    logic [HW-1:0] ins_left, ins_right;
    logic [HW-1:0] nbr_comb;

    // Handles beyond the fill count were never handed out since the last clear,
    // so their live marks in memory are stale and ignored
    assign hnd_live   = (hnd_reg != '0) && (hnd_reg <= alloc_count_reg) && live_rd;
    assign hnd_ok     = (hnd_reg == '0) || hnd_live;
    assign pool_full  = (alloc_count_reg == dllp_pkg::POOL_LAST);
    assign new_handle = alloc_count_reg + HW'(1);

    // Sentinel links live in registers, node links in memory
    assign ins_left  = (op_reg == dllp_pkg::OP_INS_AFTER) ? hnd_reg
                     : ((hnd_reg == '0) ? head_prv_reg : prv_rd);
    assign ins_right = (op_reg == dllp_pkg::OP_INS_AFTER)
                     ? ((hnd_reg == '0) ? head_nxt_reg : nxt_rd)
                     : hnd_reg;
    assign nbr_comb  = (op_reg == dllp_pkg::OP_NEXT)
                     ? ((hnd_reg == '0) ? head_nxt_reg : nxt_rd)
                     : ((hnd_reg == '0) ? head_prv_reg : prv_rd);

    // Read addresses: present the incoming handle while idle; the link address then holds
    assign link_raddr = (state_reg == dllp_pkg::ST_IDLE) ? dllp_pkg::slot_of(in_handle)
                      : dllp_pkg::slot_of(hnd_reg);

    always_comb
    begin
        unique case (state_reg)
            dllp_pkg::ST_IDLE:
            begin
                val_raddr = dllp_pkg::slot_of(in_handle);
            end
            dllp_pkg::ST_LOOK:
            begin
                val_raddr = ((op_reg == dllp_pkg::OP_NEXT) || (op_reg == dllp_pkg::OP_PREV))
                          ? dllp_pkg::slot_of(nbr_comb) : dllp_pkg::slot_of(hnd_reg);
            end
            dllp_pkg::ST_FETCH:
            begin
                val_raddr = dllp_pkg::slot_of(nbr_reg);
            end
            default:
            begin
                val_raddr = dllp_pkg::slot_of(hnd_reg);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, memory writes and result
    // ------------------------------------------------------------------
    logic              load_out;
    logic [HW-1:0]     res_handle;
    logic [VW-1:0]     res_value;
    dllp_pkg::status_t res_status;

    always_comb
    begin
        state_next       = state_reg;
        alloc_count_next = alloc_count_reg;
        head_nxt_next    = head_nxt_reg;
        head_prv_next    = head_prv_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        nbr_next         = nbr_reg;
        nxt_we           = 1'b0;
        nxt_waddr        = '0;
        nxt_wdata        = '0;
        prv_we           = 1'b0;
        prv_waddr        = '0;
        prv_wdata        = '0;
        val_we           = 1'b0;
        val_waddr        = '0;
        val_wdata        = '0;
        live_we          = 1'b0;
        live_waddr       = '0;
        live_wdata       = 1'b0;
        load_out         = 1'b0;
        res_handle       = '0;
        res_value        = '0;
        res_status       = dllp_pkg::STATUS_OK;

        unique case (state_reg)
            dllp_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = dllp_pkg::ST_LOOK;
                end
            end

            dllp_pkg::ST_LOOK:
            begin
                unique case (op_reg)
                    dllp_pkg::OP_INS_AFTER,
                    dllp_pkg::OP_INS_BEFORE:
                    begin
                        if (out_free)
                        begin
                            load_out = 1'b1;
                            if (!hnd_ok)
                            begin
                                res_status = dllp_pkg::STATUS_NOT_LIVE;
                                state_next = dllp_pkg::ST_IDLE;
                            end
                            else if (pool_full)
                            begin
                                res_status = dllp_pkg::STATUS_FULL;
                                state_next = dllp_pkg::ST_IDLE;
                            end
                            else
                            begin
                                // Write the new node whole; splice neighbors next cycle
                                nxt_we           = 1'b1;
                                nxt_waddr        = dllp_pkg::slot_of(new_handle);
                                nxt_wdata        = ins_right;
                                prv_we           = 1'b1;
                                prv_waddr        = dllp_pkg::slot_of(new_handle);
                                prv_wdata        = ins_left;
                                val_we           = 1'b1;
                                val_waddr        = dllp_pkg::slot_of(new_handle);
                                val_wdata        = val_reg;
                                live_we          = 1'b1;
                                live_waddr       = dllp_pkg::slot_of(new_handle);
                                live_wdata       = 1'b1;
                                alloc_count_next = new_handle;
                                left_next        = ins_left;
                                right_next       = ins_right;
                                res_handle       = new_handle;
                                state_next       = dllp_pkg::ST_LINK;
                            end
                        end
                    end

                    dllp_pkg::OP_ERASE:
                    begin
                        if (out_free)
                        begin
                            load_out   = 1'b1;
                            state_next = dllp_pkg::ST_IDLE;
                            if (!hnd_live)
                            begin
                                res_status = dllp_pkg::STATUS_NOT_LIVE;
                            end
                            else
                            begin
                                // Unlink: prev.next = next, next.prev = prev
                                if (prv_rd != '0)
                                begin
                                    nxt_we    = 1'b1;
                                    nxt_waddr = dllp_pkg::slot_of(prv_rd);
                                    nxt_wdata = nxt_rd;
                                end
                                else
                                begin
                                    head_nxt_next = nxt_rd;
                                end
                                if (nxt_rd != '0)
                                begin
                                    prv_we    = 1'b1;
                                    prv_waddr = dllp_pkg::slot_of(nxt_rd);
                                    prv_wdata = prv_rd;
                                end
                                else
                                begin
                                    head_prv_next = prv_rd;
                                end
                                live_we    = 1'b1;
                                live_waddr = dllp_pkg::slot_of(hnd_reg);
                                live_wdata = 1'b0;
                                res_value  = val_rd;
                            end
                        end
                    end

                    dllp_pkg::OP_NEXT,
                    dllp_pkg::OP_PREV:
                    begin
                        if (!hnd_ok)
                        begin
                            if (out_free)
                            begin
                                load_out   = 1'b1;
                                res_status = dllp_pkg::STATUS_NOT_LIVE;
                                state_next = dllp_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            // Neighbor's value read is under way this cycle
                            nbr_next   = nbr_comb;
                            state_next = dllp_pkg::ST_FETCH;
                        end
                    end

                    dllp_pkg::OP_CLEAR:
                    begin
                        if (out_free)
                        begin
                            load_out         = 1'b1;
                            alloc_count_next = '0;
                            head_nxt_next    = '0;
                            head_prv_next    = '0;
                            state_next       = dllp_pkg::ST_IDLE;
                        end
                    end

                    default:
                    begin
                        // Unused code: answer with an all-zero beat
                        if (out_free)
                        begin
                            load_out   = 1'b1;
                            state_next = dllp_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            dllp_pkg::ST_LINK:
            begin
                // Point the left neighbor forward and the right neighbor back at the new node
                if (left_reg != '0)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = dllp_pkg::slot_of(left_reg);
                    nxt_wdata = alloc_count_reg;
                end
                else
                begin
                    head_nxt_next = alloc_count_reg;
                end
                if (right_reg != '0)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = dllp_pkg::slot_of(right_reg);
                    prv_wdata = alloc_count_reg;
                end
                else
                begin
                    head_prv_next = alloc_count_reg;
                end
                state_next = dllp_pkg::ST_IDLE;
            end

            dllp_pkg::ST_FETCH:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    res_handle = nbr_reg;
                    res_value  = (nbr_reg == '0) ? '0 : val_rd;
                    state_next = dllp_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dllp_pkg::ST_IDLE;
            alloc_count_reg <= '0;
            head_nxt_reg    <= '0;
            head_prv_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            alloc_count_reg <= alloc_count_next;
            head_nxt_reg    <= head_nxt_next;
            head_prv_reg    <= head_prv_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg  <= dllp_pkg::op_t'(s_axis_tuser);
            hnd_reg <= in_handle;
            val_reg <= s_axis_tdata[HW +: VW];
        end
        left_reg  <= left_next;
        right_reg <= right_next;
        nbr_reg   <= nbr_next;
        if (load_out)
        begin
            out_handle_reg <= res_handle;
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dllp_pkg::TDATA_W - HW - VW){1'b0}}, out_value_reg, out_handle_reg};
    assign m_axis_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Fill count never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        alloc_count_reg <= dllp_pkg::POOL_LAST)
    else $error("fill count beyond pool size");

    // Fill count only steps up by one or drops to zero on clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_count_reg != $past(alloc_count_reg)) |->
        ((alloc_count_reg == $past(alloc_count_reg) + HW'(1)) || (alloc_count_reg == '0)))
    else $error("fill count moved by other than one");

    // Splice step never links the new node to itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dllp_pkg::ST_LINK) |->
        ((left_reg != alloc_count_reg) && (right_reg != alloc_count_reg)))
    else $error("new node spliced onto itself");

    // Memories are written only while an operation is being resolved
    assert property (@(posedge clk) disable iff (!rst_n)
        (nxt_we || prv_we || val_we || live_we) |->
        ((state_reg == dllp_pkg::ST_LOOK) || (state_reg == dllp_pkg::ST_LINK)))
    else $error("memory write outside of an operation");

endmodule

// ===== verif/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the linked list pool unit: streams list operations
// through a bursty sender, mirrors every accepted operation on a local copy
// of the pool, and checks each result beat field by field under receiver
// stalls, including one long hold-off that backs up the input side.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dllp_pkg::*;

    // Op codes outside the defined set; the unit answers them with all zeros
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES = 300;  // long receiver hold-off
    localparam int HOLD_AFTER  = 300;  // results to see before the hold-off
    localparam int IDLE_LIMIT  = 5000; // cycles without any beat before giving up
    localparam int DRAIN_TAIL  = 20;   // quiet cycles after the last result

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  value;
    } op_beat_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    doubly_linked_list_pool_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Local copy of the pool: links, values, live flags and fill count
    // ------------------------------------------------------------------------
    logic [HANDLE_W-1:0] lst_next [0:POOL_NODES];
    logic [HANDLE_W-1:0] lst_prev [0:POOL_NODES];
    logic [VALUE_W-1:0]  lst_val  [0:POOL_NODES];
    bit                  lst_live [0:POOL_NODES];
    int                  lst_fill;

    op_beat_t pending_ops[$];      // operations waiting to be sent
    result_t  expected_results[$]; // results owed by the unit, oldest first

    int fail_count   = 0;
    int ops_sent     = 0;
    int results_seen = 0;
    int full_seen    = 0;
    int not_live_seen = 0;

    // Empty list: sentinel points to itself, nothing live, nothing handed out
    function automatic void list_wipe();
        for (int i = 0; i <= POOL_NODES; i++)
        begin
            lst_next[i] = '0;
            lst_prev[i] = '0;
            lst_val[i]  = '0;
            lst_live[i] = 1'b0;
        end
        lst_fill = 0;
    endfunction

    // Apply one operation to the local pool and return the result it owes
    function automatic result_t list_step(input op_beat_t b);
        result_t             r;
        logic [HANDLE_W-1:0] h;
        logic [HANDLE_W-1:0] n;
        logic [HANDLE_W-1:0] lo;
        logic [HANDLE_W-1:0] hi;
        logic [HANDLE_W-1:0] m;
        bit                  live;
        r    = '0;
        h    = b.handle;
        // Handles past the pool are never live; the sentinel always is
        live = (h <= POOL_LAST) && ((h == '0) || lst_live[h]);
        case (b.op)
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                // Handle check wins over the full check
                if (!live)
                    r.status = STATUS_NOT_LIVE;
                else if (lst_fill == POOL_NODES)
                    r.status = STATUS_FULL;
                else
                begin
                    n = HANDLE_W'(lst_fill + 1);
                    if (b.op == OP_INS_AFTER)
                    begin
                        lo = h;
                        hi = lst_next[h];
                    end
                    else
                    begin
                        lo = lst_prev[h];
                        hi = h;
                    end
                    lst_val[n]  = b.value;
                    lst_prev[n] = lo;
                    lst_next[n] = hi;
                    lst_next[lo] = n;
                    lst_prev[hi] = n;
                    lst_live[n] = 1'b1;
                    lst_fill++;
                    r.handle = n;
                end
            end
            OP_ERASE:
            begin
                // The sentinel can never be erased
                if (h == '0 || !live)
                    r.status = STATUS_NOT_LIVE;
                else
                begin
                    lo = lst_prev[h];
                    hi = lst_next[h];
                    lst_next[lo] = hi;
                    lst_prev[hi] = lo;
                    lst_live[h] = 1'b0;
                    r.value = lst_val[h];
                end
            end
            OP_NEXT, OP_PREV:
            begin
                if (!live)
                    r.status = STATUS_NOT_LIVE;
                else
                begin
                    m = (b.op == OP_NEXT) ? lst_next[h] : lst_prev[h];
                    r.handle = m;
                    r.value  = (m == '0) ? '0 : lst_val[m];
                end
            end
            OP_CLEAR:
                list_wipe();
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus bookkeeping: which handles the generator may aim at
    // ------------------------------------------------------------------------
    int gen_fill = 0;
    bit gen_live [0:POOL_NODES];
    int live_handles[$];
    int dead_handles[$];

    // Queue one operation and track handle allocation so later picks stay valid
    function automatic void add_op(input logic [OP_W-1:0] op, input int h,
                                   input logic [VALUE_W-1:0] v);
        bit ok;
        int hit[$];
        ok = (h <= POOL_NODES) && (h == 0 || gen_live[h]);
        pending_ops.push_back('{op, HANDLE_W'(h), v});
        case (op)
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                if (ok && gen_fill < POOL_NODES)
                begin
                    gen_fill++;
                    gen_live[gen_fill] = 1'b1;
                    live_handles.push_back(gen_fill);
                end
            end
            OP_ERASE:
            begin
                if (ok && h != 0)
                begin
                    gen_live[h] = 1'b0;
                    hit = live_handles.find_first_index(x) with (x == h);
                    live_handles.delete(hit[0]);
                    dead_handles.push_back(h);
                end
            end
            OP_CLEAR:
            begin
                gen_fill = 0;
                gen_live = '{default: 1'b0};
                live_handles.delete();
                dead_handles.delete();
            end
            default:
                ;
        endcase
    endfunction

    // Mostly random patterns, now and then the all-zero or all-one extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A live handle most of the time, the sentinel otherwise
    function automatic int pick_live();
        if (live_handles.size() == 0 || $urandom_range(0, 9) == 0)
            return 0;
        return live_handles[$urandom_range(0, live_handles.size() - 1)];
    endfunction

    // Handles that should be refused: erased, past the pool, or anything
    function automatic int pick_stray();
        case ($urandom_range(0, 2))
            0:
            begin
                if (dead_handles.size() != 0)
                    return dead_handles[$urandom_range(0, dead_handles.size() - 1)];
                return POOL_NODES;
            end
            1:       return $urandom_range(POOL_NODES + 1, (1 << HANDLE_W) - 1);
            default: return $urandom_range(0, (1 << HANDLE_W) - 1);
        endcase
    endfunction

    // One random operation; ins_pct sets the share of inserts on live handles
    function automatic void add_random_op(input int ins_pct, input bit allow_clear);
        int               r;
        logic [OP_W-1:0]  op;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
        begin
            op = $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
            add_op(op, pick_live(), pick_value());
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 30)
            add_op(OP_ERASE, pick_live(), pick_value());
        else if (r < 55)
            add_op(OP_NEXT, pick_live(), pick_value());
        else if (r < 80)
            add_op(OP_PREV, pick_live(), pick_value());
        else if (r < 84 && allow_clear)
            add_op(OP_CLEAR, pick_live(), pick_value());
        else if (r < 95)
        begin
            // Noise: any code on a handle that is likely refused
            op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
            if (op == OP_CLEAR && !allow_clear)
                op = OP_NEXT;
            add_op(op, pick_stray(), pick_value());
        end
        else
            add_op($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI,
                   pick_stray(), pick_value());
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sender: pop operations into the input stream in bursts with gaps
    // ------------------------------------------------------------------------
    int       burst_left = 0;
    int       gap_left   = 0;
    op_beat_t send_beat;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            // Slot frees up at this edge: idle out the gap, else load the next beat
            if (gap_left != 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                send_beat      = pending_ops.pop_front();
                s_axis_tdata  <= TDATA_W'({send_beat.value, send_beat.handle});
                s_axis_tuser  <= send_beat.op;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    // Start a new burst; a quarter of them follow with no gap
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall in windows of varying density, plus one long hold-off
    // once enough results have come back, while the sender keeps offering
    // ------------------------------------------------------------------------
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    int  rx_count    = 0;
    int  window_left = 0;
    int  stall_pct   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_count <= rx_count + 1;
            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && rx_count >= HOLD_AFTER)
            begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (window_left == 0)
                begin
                    // New window: no stalls, light, medium or heavy
                    window_left <= $urandom_range(16, 64);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct <= 0;
                        2:       stall_pct <= 20;
                        3:       stall_pct <= 50;
                        default: stall_pct <= 85;
                    endcase
                end
                else
                    window_left <= window_left - 1;
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predict on every accepted operation, check every result beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        op_beat_t took;
        result_t  want;
        result_t  got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                took.op     = s_axis_tuser;
                took.handle = s_axis_tdata[HANDLE_W-1:0];
                took.value  = s_axis_tdata[HANDLE_W +: VALUE_W];
                expected_results.push_back(list_step(took));
                ops_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.handle = m_axis_tdata[HANDLE_W-1:0];
                got.value  = m_axis_tdata[HANDLE_W +: VALUE_W];
                got.status = m_axis_tuser;
                results_seen++;
                if (got.status == STATUS_FULL)
                    full_seen++;
                if (got.status == STATUS_NOT_LIVE)
                    not_live_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: handle %0d value %h status %0d",
                             $time, got.handle, got.value, got.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.handle !== want.handle)
                    begin
                        $display("%0t: result handle mismatch: expected %0d, actual %0d",
                                 $time, want.handle, got.handle);
                        fail_count++;
                    end
                    if (got.value !== want.value)
                    begin
                        $display("%0t: result value mismatch: expected %h, actual %h",
                                 $time, want.value, got.value);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: abort when no beat moves on either side for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, expected_results.size());
                $display("[doubly_linked_list_pool_unit] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        list_wipe();
        gen_live = '{default: 1'b0};

        // Directed: empty list walks, sentinel erase, building a short list,
        // walking it both ways, stale and out-of-pool handles, spare codes,
        // clear and handle numbering restarting after it
        add_op(OP_NEXT,       0, '0);
        add_op(OP_PREV,       0, '1);
        add_op(OP_ERASE,      0, '0);
        add_op(OP_ERASE,      1, '0);
        add_op(OP_INS_AFTER,  0, '1);
        add_op(OP_INS_BEFORE, 0, '0);
        add_op(OP_INS_AFTER,  1, 64'h8000_0000_0000_0001);
        add_op(OP_INS_BEFORE, 1, 64'h5555_5555_5555_5555);
        add_op(OP_NEXT,       0, '0);
        add_op(OP_PREV,       0, '0);
        add_op(OP_NEXT,       3, '0);
        add_op(OP_PREV,       4, '0);
        add_op(OP_NEXT,       2, '0);
        add_op(OP_ERASE,      3, '0);
        add_op(OP_NEXT,       3, '0);
        add_op(OP_INS_AFTER,  3, 64'h0123_4567_89AB_CDEF);
        add_op(OP_ERASE,      3, '0);
        add_op(OP_NEXT,       POOL_NODES, '0);
        add_op(OP_PREV,       POOL_NODES + 1, '0);
        add_op(OP_INS_BEFORE, (1 << HANDLE_W) - 1, '1);
        add_op(OP_SPARE_LO,   1, 64'hFEDC_BA98_7654_3210);
        add_op(OP_SPARE_HI,   (1 << HANDLE_W) - 1, '1);
        add_op(OP_CLEAR,      0, '0);
        add_op(OP_NEXT,       0, '0);
        add_op(OP_INS_AFTER,  0, 64'hAAAA_AAAA_AAAA_AAAA);

        // Mixed traffic with occasional clears
        repeat (40)
            add_random_op(40, 1'b1);

        // Fill the pool to the brim, then keep pushing so inserts report full
        add_op(OP_CLEAR, 0, '0);
        while (gen_fill < POOL_NODES)
            add_random_op(95, 1'b0);
        repeat (20)
            add_random_op(50, 1'b0);

        // Clear out of the full state and finish with mixed traffic
        add_op(OP_CLEAR, 0, '0);
        repeat (10)
            add_random_op(40, 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every operation sent and every owed result back, then linger
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("tb: %0d operations sent, %0d results checked (%0d pool full, %0d not live)",
                 ops_sent, results_seen, full_seen, not_live_seen);
        $display("tb: pool filled to %0d nodes, receiver held off for %0d cycles once",
                 POOL_NODES, HOLD_CYCLES);
        if (fail_count == 0)
            $display("[doubly_linked_list_pool_unit] OK");
        else
            $display("[doubly_linked_list_pool_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dllp_pkg.sv
src/dllp_ram.sv
src/doubly_linked_list_pool_unit.sv
verif/tb.sv
